// ===== rtl/ftfes_pkg.sv =====
// shared types, constants and register codes of the free extent scanner
`default_nettype none
package ftfes_pkg;

    // fixed field widths
    localparam int BYTE_W     = 8;
    localparam int KIND_W     = 2;
    localparam int COUNT_W    = 28;
    localparam int DATA_W     = 64;
    localparam int BPC_W      = 20;
    localparam int CFG_IDX_W  = 2;

    // default index width and queue depths
    localparam int INDEX_BITS_DEF = 28;
    localparam int MID_DEPTH      = 4;
    localparam int OUT_DEPTH      = 4;

    // entry format codes; any code with the wide bit set reads 32-bit entries
    localparam logic [KIND_W-1:0] KIND_FAT12    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FAT16    = 2'd1;
    localparam int                KIND_WIDE_BIT = 1;

    // FAT32 entries keep the low 28 bits
    localparam logic [31:0] FAT32_MASK = 32'h0FFF_FFFF;

    // register reset values
    localparam logic [KIND_W-1:0]  RST_FAT_KIND      = KIND_FAT12;
    localparam logic [COUNT_W-1:0] RST_CLUSTER_COUNT = 28'd1;
    localparam logic [DATA_W-1:0]  RST_DATA_START    = 64'd0;
    localparam logic [BPC_W-1:0]   RST_BPC           = 20'd512;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FAT_KIND          = 2'd0,
        CFG_CLUSTER_COUNT     = 2'd1,
        CFG_DATA_START        = 2'd2,
        CFG_BYTES_PER_CLUSTER = 2'd3
    } t_cfg_idx;

    // configuration as seen by front and back
    typedef struct packed {
        logic [KIND_W-1:0]  fat_kind;
        logic [COUNT_W-1:0] cluster_count;
        logic [DATA_W-1:0]  data_start;
        logic [BPC_W-1:0]   bytes_per_cluster;
    } t_cfg;

    // flags that travel with each request
    typedef struct packed {
        logic has_range;
        logic end_of_table;
    } t_job_flags;

endpackage
`default_nettype wire

// ===== rtl/fat_table_free_extent_scanner_core.sv =====
// top level of the FAT free extent scanner
// Takes one allocation table byte per clock and reports each closed run of free
// clusters as a byte range [start, end) on the device, plus one result flagged
// end_of_table for the last byte. The front assembles FAT12, FAT16 or FAT32
// entries and tracks runs at a sustained rate of one byte per cycle; closed runs
// pass through a four-entry request queue to a two-stage offset unit (multiply by
// cluster size, then add data_start) and a four-entry result queue. push is refused
// only while the request queue is full, which happens only when results are not
// being popped. Configuration must be written while no table byte is in progress.
`default_nettype none
module fat_table_free_extent_scanner_core #(
    parameter int INDEX_BITS = ftfes_pkg::INDEX_BITS_DEF,
    parameter int MID_DEPTH  = ftfes_pkg::MID_DEPTH,
    parameter int OUT_DEPTH  = ftfes_pkg::OUT_DEPTH
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            push,
    output logic                                 full,
    input  wire logic [ftfes_pkg::BYTE_W-1:0]    i_table_byte,
    input  wire logic                            i_last_byte,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [ftfes_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [ftfes_pkg::DATA_W-1:0]    i_cfg_data,
    output logic                                 empty,
    input  wire logic                            pop,
    output logic      [ftfes_pkg::DATA_W-1:0]    o_range_start,
    output logic      [ftfes_pkg::DATA_W-1:0]    o_range_end,
    output logic                                 o_has_range,
    output logic                                 o_end_of_table
);
    import ftfes_pkg::*;

    localparam int END_W = (INDEX_BITS > COUNT_W) ? INDEX_BITS : COUNT_W;
    localparam int JW    = INDEX_BITS + END_W + $bits(t_job_flags);

    t_cfg                  r_cfg;
    logic                  w_take;
    logic                  w_job_valid;
    logic [INDEX_BITS-1:0] w_job_start;
    logic [END_W-1:0]      w_job_end;
    t_job_flags            w_job_flags;
    logic [JW-1:0]         w_mid_data;
    logic                  w_mid_empty;
    logic                  w_mid_pop;
    logic [$clog2(MID_DEPTH + 1)-1:0] w_mid_count;

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fat_kind          <= RST_FAT_KIND;
            r_cfg.cluster_count     <= RST_CLUSTER_COUNT;
            r_cfg.data_start        <= RST_DATA_START;
            r_cfg.bytes_per_cluster <= RST_BPC;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_FAT_KIND:          r_cfg.fat_kind          <= i_cfg_data[KIND_W-1:0];
                CFG_CLUSTER_COUNT:     r_cfg.cluster_count     <= i_cfg_data[COUNT_W-1:0];
                CFG_DATA_START:        r_cfg.data_start        <= i_cfg_data;
                CFG_BYTES_PER_CLUSTER: r_cfg.bytes_per_cluster <= i_cfg_data[BPC_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // front
    assign w_take = push && !full;

    ftfes_front #(
        .INDEX_BITS (INDEX_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_take       (w_take),
        .i_table_byte (i_table_byte),
        .i_last_byte  (i_last_byte),
        .o_job_valid  (w_job_valid),
        .o_job_start  (w_job_start),
        .o_job_end    (w_job_end),
        .o_job_flags  (w_job_flags)
    );

    // request queue between front and back
    ftfes_queue #(
        .WIDTH (JW),
        .DEPTH (MID_DEPTH)
    ) u_mid_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_job_valid),
        .i_data  ({w_job_start, w_job_end, w_job_flags}),
        .o_full  (full),
        .i_pop   (w_mid_pop),
        .o_data  (w_mid_data),
        .o_empty (w_mid_empty),
        .o_count (w_mid_count)
    );

    // back
    ftfes_back #(
        .INDEX_BITS (INDEX_BITS),
        .OUT_DEPTH  (OUT_DEPTH)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_job_empty    (w_mid_empty),
        .i_job_start    (w_mid_data[JW-1 -: INDEX_BITS]),
        .i_job_end      (w_mid_data[JW-INDEX_BITS-1 -: END_W]),
        .i_job_flags    (w_mid_data[$bits(t_job_flags)-1:0]),
        .o_job_pop      (w_mid_pop),
        .o_empty        (empty),
        .i_pop          (pop),
        .o_range_start  (o_range_start),
        .o_range_end    (o_range_end),
        .o_has_range    (o_has_range),
        .o_end_of_table (o_end_of_table)
    );

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        full |-> (w_mid_count != '0 && !w_mid_empty))
        else $error("request queue full with nothing queued");

endmodule
`default_nettype wire

// ===== rtl/ftfes_queue.sv =====
// small register-based first-in first-out queue
`default_nettype none
module ftfes_queue #(
    parameter int  WIDTH = 8,
    parameter int  DEPTH = ftfes_pkg::MID_DEPTH,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW    = $clog2(DEPTH + 1)
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic      [WIDTH-1:0] o_data,
    output logic                  o_empty,
    output logic      [CW-1:0]    o_count
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count,  n_count;
    logic             w_do_push, w_do_pop;

    assign o_full    = (r_count == CW'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign o_count   = r_count;
    assign o_data    = r_mem[r_rd_ptr];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;

    // pointer and fill count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_do_push) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_do_pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_do_push && !w_do_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_do_pop && !w_do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue fill count above depth");

    a_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pop && o_empty && !i_push) |=> (r_count == '0))
        else $error("pop on empty queue changed fill count");

endmodule
`default_nettype wire

// ===== rtl/ftfes_front.sv =====
// front: entry assembly, free run tracking and range requests
`default_nettype none
module ftfes_front #(
    parameter int  INDEX_BITS = ftfes_pkg::INDEX_BITS_DEF,
    localparam int END_W = (INDEX_BITS > ftfes_pkg::COUNT_W) ? INDEX_BITS : ftfes_pkg::COUNT_W
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire ftfes_pkg::t_cfg             i_cfg,
    input  wire logic                        i_take,
    input  wire logic [ftfes_pkg::BYTE_W-1:0] i_table_byte,
    input  wire logic                        i_last_byte,
    output logic                             o_job_valid,
    output logic      [INDEX_BITS-1:0]       o_job_start,
    output logic      [END_W-1:0]            o_job_end,
    output ftfes_pkg::t_job_flags            o_job_flags
);
    import ftfes_pkg::*;

    localparam int CN_W  = INDEX_BITS + 1;
    localparam int CMP_W = ((CN_W > COUNT_W) ? CN_W : COUNT_W) + 1;
    localparam logic [CN_W-1:0] CN_MAX = '1;

    logic [1:0]            r_byte_phase, n_byte_phase;
    logic [23:0]           r_held,       n_held;
    logic [CN_W-1:0]       r_cluster,    n_cluster;
    logic                  r_in_run,     n_in_run;
    logic [INDEX_BITS-1:0] r_run_start,  n_run_start;
    logic                  r_reached,    n_reached;

    logic [BYTE_W-1:0] w_prev0;
    logic              w_done;
    logic              w_zero;
    logic              w_emit;
    logic [CMP_W-1:0]  w_idx;
    logic [CMP_W-1:0]  w_cc;
    logic [CMP_W-1:0]  w_seen;
    logic [CMP_W-1:0]  w_end;

    // entry assembly by format
    always_comb begin
        w_prev0      = r_held[7:0];
        w_done       = 1'b0;
        w_zero       = 1'b0;
        n_byte_phase = r_byte_phase;
        if (i_cfg.fat_kind[KIND_WIDE_BIT]) begin
            if (r_byte_phase == 2'd3) begin
                w_done       = 1'b1;
                w_zero       = (({i_table_byte, w_prev0, r_held[15:8], r_held[23:16]}
                                 & FAT32_MASK) == '0);
                n_byte_phase = 2'd0;
            end else begin
                n_byte_phase = r_byte_phase + 2'd1;
            end
        end else if (i_cfg.fat_kind == KIND_FAT16) begin
            if (r_byte_phase[0]) begin
                w_done       = 1'b1;
                w_zero       = ({i_table_byte, w_prev0} == '0);
                n_byte_phase = 2'd0;
            end else begin
                n_byte_phase = 2'd1;
            end
        end else begin
            case (r_byte_phase)
                2'd1: begin
                    w_done       = 1'b1;
                    w_zero       = ({i_table_byte[3:0], w_prev0} == '0);
                    n_byte_phase = 2'd2;
                end
                2'd2: begin
                    w_done       = 1'b1;
                    w_zero       = ({i_table_byte, w_prev0[7:4]} == '0);
                    n_byte_phase = 2'd0;
                end
                default: begin
                    n_byte_phase = 2'd1;
                end
            endcase
        end
        n_held = {r_held[15:0], i_table_byte};
    end

    // run tracking and closing
    always_comb begin
        w_cc        = CMP_W'(i_cfg.cluster_count);
        w_idx       = CMP_W'(r_cluster) - CMP_W'(2);
        n_cluster   = r_cluster;
        n_in_run    = r_in_run;
        n_run_start = r_run_start;
        n_reached   = r_reached;
        w_emit      = 1'b0;
        w_end       = '0;
        w_seen      = '0;
        if (w_done) begin
            if (r_cluster != CN_MAX) begin
                n_cluster = r_cluster + 1'b1;
            end
            if ((r_cluster >= CN_W'(2)) && !r_reached) begin
                if (w_idx < w_cc) begin
                    if (w_zero) begin
                        if (!r_in_run) begin
                            n_run_start = w_idx[INDEX_BITS-1:0];
                            n_in_run    = 1'b1;
                        end
                    end else if (r_in_run) begin
                        w_emit   = 1'b1;
                        w_end    = w_idx;
                        n_in_run = 1'b0;
                    end
                end
                if ((w_idx + CMP_W'(1)) >= w_cc) begin
                    n_reached = 1'b1;
                end
            end
        end
        // an open run closes at the end of the table
        if (i_last_byte && n_in_run) begin
            w_seen = (n_cluster >= CN_W'(2)) ? (CMP_W'(n_cluster) - CMP_W'(2)) : '0;
            w_end  = (w_seen < w_cc) ? w_seen : w_cc;
            if (w_end < CMP_W'(n_run_start)) begin
                w_end = CMP_W'(n_run_start);
            end
            w_emit = 1'b1;
        end
    end

    // request towards the back
    assign o_job_valid              = i_take && (w_emit || i_last_byte);
    assign o_job_start              = n_run_start;
    assign o_job_end                = w_end[END_W-1:0];
    assign o_job_flags.has_range    = w_emit;
    assign o_job_flags.end_of_table = i_last_byte;

    // scan state, cleared after the last byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_phase <= '0;
            r_held       <= '0;
            r_cluster    <= '0;
            r_in_run     <= 1'b0;
            r_run_start  <= '0;
            r_reached    <= 1'b0;
        end else if (i_take) begin
            if (i_last_byte) begin
                r_byte_phase <= '0;
                r_held       <= '0;
                r_cluster    <= '0;
                r_in_run     <= 1'b0;
                r_run_start  <= '0;
                r_reached    <= 1'b0;
            end else begin
                r_byte_phase <= n_byte_phase;
                r_held       <= n_held;
                r_cluster    <= n_cluster;
                r_in_run     <= n_in_run;
                r_run_start  <= n_run_start;
                r_reached    <= n_reached;
            end
        end
    end

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_take && i_last_byte) |=> (r_cluster == '0 && !r_in_run && !r_reached))
        else $error("scan state not cleared after last byte");

endmodule
`default_nettype wire

// ===== rtl/ftfes_back.sv =====
// back: scales run indices to byte offsets and queues the results
`default_nettype none
module ftfes_back #(
    parameter int  INDEX_BITS = ftfes_pkg::INDEX_BITS_DEF,
    parameter int  OUT_DEPTH  = ftfes_pkg::OUT_DEPTH,
    localparam int END_W = (INDEX_BITS > ftfes_pkg::COUNT_W) ? INDEX_BITS : ftfes_pkg::COUNT_W
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire ftfes_pkg::t_cfg              i_cfg,
    input  wire logic                         i_job_empty,
    input  wire logic [INDEX_BITS-1:0]        i_job_start,
    input  wire logic [END_W-1:0]             i_job_end,
    input  wire ftfes_pkg::t_job_flags        i_job_flags,
    output logic                              o_job_pop,
    output logic                              o_empty,
    input  wire logic                         i_pop,
    output logic      [ftfes_pkg::DATA_W-1:0] o_range_start,
    output logic      [ftfes_pkg::DATA_W-1:0] o_range_end,
    output logic                              o_has_range,
    output logic                              o_end_of_table
);
    import ftfes_pkg::*;

    localparam int PW   = END_W + BPC_W;
    localparam int OCW  = $clog2(OUT_DEPTH + 1);
    localparam int SUMW = OCW + 1;
    localparam int QW   = 2 * DATA_W + $bits(t_job_flags);

    logic             r_s1_valid;
    t_job_flags       r_s1_flags;
    logic [PW-1:0]    r_s1_prod_start;
    logic [PW-1:0]    r_s1_prod_end;
    logic             r_s2_valid;
    t_job_flags       r_s2_flags;
    logic [DATA_W-1:0] r_s2_start;
    logic [DATA_W-1:0] r_s2_end;

    logic [PW-1:0]    w_prod_start;
    logic [PW-1:0]    w_prod_end;
    logic [OCW-1:0]   w_out_count;
    logic [SUMW-1:0]  w_committed;
    logic             w_out_full;
    logic [QW-1:0]    w_out_data;
    t_job_flags       w_out_flags;

    // issue only when the result queue has room for everything in flight
    assign w_committed = SUMW'(w_out_count) + SUMW'(r_s1_valid) + SUMW'(r_s2_valid);
    assign o_job_pop   = !i_job_empty && (w_committed < SUMW'(OUT_DEPTH));

    // stage one: index times cluster size
    assign w_prod_start = PW'(i_job_start) * PW'(i_cfg.bytes_per_cluster);
    assign w_prod_end   = PW'(i_job_end) * PW'(i_cfg.bytes_per_cluster);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            r_s1_valid <= o_job_pop;
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_flags      <= i_job_flags;
        r_s1_prod_start <= w_prod_start;
        r_s1_prod_end   <= w_prod_end;
    end

    // stage two: add the data area offset, zero when no run
    always_ff @(posedge i_clk) begin
        r_s2_flags <= r_s1_flags;
        if (r_s1_flags.has_range) begin
            r_s2_start <= i_cfg.data_start + DATA_W'(r_s1_prod_start);
            r_s2_end   <= i_cfg.data_start + DATA_W'(r_s1_prod_end);
        end else begin
            r_s2_start <= '0;
            r_s2_end   <= '0;
        end
    end

    // result queue
    ftfes_queue #(
        .WIDTH (QW),
        .DEPTH (OUT_DEPTH)
    ) u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_s2_valid),
        .i_data  ({r_s2_start, r_s2_end, r_s2_flags}),
        .o_full  (w_out_full),
        .i_pop   (i_pop),
        .o_data  (w_out_data),
        .o_empty (o_empty),
        .o_count (w_out_count)
    );

    assign o_range_start  = w_out_data[QW-1 -: DATA_W];
    assign o_range_end    = w_out_data[QW-DATA_W-1 -: DATA_W];
    assign w_out_flags    = w_out_data[$bits(t_job_flags)-1:0];
    assign o_has_range    = w_out_flags.has_range;
    assign o_end_of_table = w_out_flags.end_of_table;

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_valid |-> !w_out_full)
        else $error("result written into full queue");

endmodule
`default_nettype wire
